>>> src/dfa_pkg.sv
// decimal float alu: shared types, codes and constants
// used by the wide arithmetic unit, the top level and the testbench
package dfa_pkg;

  // command codes
  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_MUL  = 3'd1;
  localparam logic [2:0] CMD_CMP  = 3'd2;
  localparam logic [2:0] CMD_NORM = 3'd3;
  localparam logic [2:0] CMD_TOINT = 3'd4;
  localparam logic [2:0] CMD_NEG  = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_BAD_ARG  = 3'd2;
  localparam logic [2:0] ST_NEGATIVE = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam int WIDE_W = 128;

  // normalized mantissa window and exponent limits
  localparam logic [WIDE_W-1:0] MANT_LOW  = 128'd1000000000000000;
  localparam logic [WIDE_W-1:0] MANT_HIGH = 128'd9999999999999999;
  localparam logic [WIDE_W-1:0] INT_LIMIT = 128'd922337203685477580;
  localparam logic signed [10:0] EXP_LOW  = -11'sd96;
  localparam logic signed [10:0] EXP_HIGH = 11'sd80;
  localparam logic signed [10:0] EXP_BIAS = 11'sd97;
  localparam logic signed [9:0]  GAP_LIMIT = 10'sd20;
  localparam logic [7:0]         DIV_CAP = 8'd21;

  // divide by ten on a 20-bit partial remainder: (x * magic) >> 23
  localparam logic [19:0] DIV_MAGIC = 20'd838861;

  typedef enum logic [2:0] {
    UOP_MUL10,
    UOP_DIV,
    UOP_ADD,
    UOP_SUB,
    UOP_RSB,
    UOP_MAC
  } uop_t;

  typedef struct packed {
    uop_t       uop;
    logic [2:0] idx;
    logic [3:0] rem;
    logic [1:0] pp_sh;
  } wctl_t;

  typedef struct packed {
    logic       gt;
    logic       eq;
    logic [3:0] rem;
  } wsts_t;

endpackage

>>> src/dfa_if.sv
// request and result channels of the decimal float alu
// depends on nothing but plain logic types
interface dfa_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;
  logic signed [7:0]  exponent_in;
  logic [2:0]         compare_mode;
  logic [4:0]         frac_digits;
  logic               take_magnitude;

  modport source (output valid, cmd, operand_a, operand_b, exponent_in, compare_mode,
                  frac_digits, take_magnitude, input ready);
  modport sink (input valid, cmd, operand_a, operand_b, exponent_in, compare_mode,
                frac_digits, take_magnitude, output ready);
endinterface

interface dfa_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic [2:0]         status;

  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

>>> src/dfa_wide_unit.sv
// shared 128-bit unit: times ten, one 16-bit limb of a divide by ten,
// add, subtract, partial product accumulate and a magnitude compare; uses dfa_pkg
module dfa_wide_unit (
  input  dfa_pkg::wctl_t ctl,
  input  logic [127:0]   x_i,
  input  logic [127:0]   y_i,
  input  logic [26:0]    pa_i,
  input  logic [26:0]    pb_i,
  output logic [127:0]   res_o,
  output dfa_pkg::wsts_t sts_o
);

  logic [19:0]  cur;
  logic [39:0]  prod;
  logic [15:0]  q;
  logic [19:0]  qx10;
  logic [53:0]  pp;
  logic [127:0] ppw;

  // limb divide by ten, remainder carried to the next lower limb
  always_comb begin
    cur  = {ctl.rem, x_i[ctl.idx*16 +: 16]};
    prod = 40'(cur) * 40'(dfa_pkg::DIV_MAGIC);
    q    = prod[38:23];
    qx10 = {1'b0, q, 3'b000} + {3'b000, q, 1'b0};
  end

  // partial product, placed at 0, 27 or 54 bits
  always_comb begin
    pp = 54'(pa_i) * 54'(pb_i);
    case (ctl.pp_sh)
      2'd0:    ppw = {74'd0, pp};
      2'd1:    ppw = {74'd0, pp} << 27;
      default: ppw = {74'd0, pp} << 54;
    endcase
  end

  // result select
  always_comb begin
    res_o = x_i;
    case (ctl.uop)
      dfa_pkg::UOP_MUL10: res_o = (x_i << 3) + (x_i << 1);
      dfa_pkg::UOP_DIV:   res_o[ctl.idx*16 +: 16] = q;
      dfa_pkg::UOP_ADD:   res_o = x_i + y_i;
      dfa_pkg::UOP_SUB:   res_o = x_i - y_i;
      dfa_pkg::UOP_RSB:   res_o = y_i - x_i;
      dfa_pkg::UOP_MAC:   res_o = x_i + ppw;
      default:            res_o = x_i;
    endcase
  end

  // compare and remainder out
  always_comb begin
    sts_o.gt  = x_i > y_i;
    sts_o.eq  = x_i == y_i;
    sts_o.rem = 4'(cur - qx10);
  end

endmodule

>>> src/decimal_float_alu_top.sv
// decimal float alu top level: request/result handshake and operation sequencer
// depends on dfa_pkg, dfa_if and dfa_wide_unit
//
// Usage: one request on in_chan (valid/ready) carries a command and its operands;
// exactly one result (value and status) follows on out_chan (valid/ready).
// The block takes one request at a time: in_chan.ready is high only while idle.
// Every step runs through one shared 128-bit unit under a small sequencer:
//   negate, distant-exponent compare, errors: decided in the start state
//   add/compare: times ten per digit of gap (at most 20), compare, then for add an
//     add or subtract; multiply: four partial products; both then normalize
//   normalize: times ten per digit shifted up, divide by ten per digit shifted
//     down (divide by ten is eight 16-bit limb steps of the shared unit)
//   to integer: times ten per digit scaled up, divide by ten over the four low
//     limbs per digit dropped (at most 21)
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops any
// pending result. A result waits in its output register while out_chan.ready
// is low; no new request is taken until it has been delivered.
module decimal_float_alu_top (
  input logic        clk,
  input logic        rst_n,
  dfa_req_if.sink    in_chan,
  dfa_rsp_if.source  out_chan
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SCALE, S_CMP, S_ARITH, S_MUL,
    S_PK_HI, S_PK_LO, S_DIV, S_TI_MUL, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]   cmd_r;
  logic [63:0]  a_r, b_r;
  logic [7:0]   exp_r;
  logic [2:0]   mode_r;
  logic [4:0]   dp_r;
  logic         take_r;

  logic [127:0] wa_r, wa_nxt, wb_r, wb_nxt;
  logic signed [10:0] e_r, e_nxt;
  logic         neg_r, neg_nxt, sx_r, sx_nxt, sy_r, sy_nxt, xa_r, xa_nxt, gt_r, gt_nxt;
  logic [7:0]   cnt_r, cnt_nxt;
  logic [2:0]   idx_r, idx_nxt;
  logic [3:0]   rem_r, rem_nxt;
  logic [1:0]   step_r, step_nxt;
  logic [63:0]  res_r, res_nxt;
  logic [2:0]   st_r, st_nxt;

  dfa_pkg::wctl_t ctl;
  dfa_pkg::wsts_t sts;
  logic [127:0] y_sel, u_res;
  logic [26:0]  pa, pb;

  // operand decode
  logic [53:0]       ma, mb;
  logic signed [8:0] ea, eb;
  logic              na, nb;
  logic signed [9:0] gap, kk, negk;
  logic [63:0]       nmag;
  logic              u_lt, a_gt, a_lt;

  function automatic logic rel_bit(input logic gt, input logic lt, input logic neg,
                                   input logic [2:0] mode);
    logic r_lt, r_gt;
    begin
      r_lt = neg ? gt : lt;
      r_gt = neg ? lt : gt;
      rel_bit = r_lt ? mode[0] : (r_gt ? mode[2] : mode[1]);
    end
  endfunction

  always_comb begin
    ma   = a_r[53:0];
    mb   = b_r[53:0];
    ea   = (a_r == 64'd0) ? 9'sd0 : $signed({1'b0, a_r[61:54]}) - 9'sd97;
    eb   = (b_r == 64'd0) ? 9'sd0 : $signed({1'b0, b_r[61:54]}) - 9'sd97;
    na   = (a_r != 64'd0) && !a_r[62];
    nb   = (b_r != 64'd0) && !b_r[62];
    gap  = 10'(ea) - 10'(eb);
    kk   = 10'(ea) + $signed({5'd0, dp_r});
    negk = -kk;
    nmag = a_r[63] ? (64'd0 - a_r) : a_r;
  end

  // shared unit hookup
  always_comb begin
    ctl.uop   = dfa_pkg::UOP_MUL10;
    ctl.idx   = idx_r;
    ctl.rem   = rem_r;
    ctl.pp_sh = 2'(step_r[0]) + 2'(step_r[1]);
    case (state_r)
      S_DIV:   ctl.uop = dfa_pkg::UOP_DIV;
      S_MUL:   ctl.uop = dfa_pkg::UOP_MAC;
      S_ARITH: ctl.uop = (sx_r == sy_r) ? dfa_pkg::UOP_ADD :
                         (gt_r ? dfa_pkg::UOP_SUB : dfa_pkg::UOP_RSB);
      default: ctl.uop = dfa_pkg::UOP_MUL10;
    endcase
    case (state_r)
      S_PK_HI: y_sel = dfa_pkg::MANT_HIGH;
      S_PK_LO: y_sel = dfa_pkg::MANT_LOW;
      default: y_sel = wb_r;
    endcase
    pa = step_r[1] ? ma[53:27] : ma[26:0];
    pb = step_r[0] ? mb[53:27] : mb[26:0];
  end

  dfa_wide_unit u_wide (
    .ctl   (ctl),
    .x_i   (wa_r),
    .y_i   (y_sel),
    .pa_i  (pa),
    .pb_i  (pb),
    .res_o (u_res),
    .sts_o (sts)
  );

  always_comb begin
    u_lt = !sts.gt && !sts.eq;
    a_gt = xa_r ? sts.gt : u_lt;
    a_lt = xa_r ? u_lt : sts.gt;
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    wa_nxt = wa_r;   wb_nxt = wb_r;   e_nxt = e_r;
    neg_nxt = neg_r; sx_nxt = sx_r;   sy_nxt = sy_r; xa_nxt = xa_r; gt_nxt = gt_r;
    cnt_nxt = cnt_r; idx_nxt = idx_r; rem_nxt = rem_r; step_nxt = step_r;
    res_nxt = res_r; st_nxt = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) state_nxt = S_START;
      end
      S_START: begin
        res_nxt   = 64'd0;
        st_nxt    = dfa_pkg::ST_OK;
        state_nxt = S_OUT;
        // align setup shared by add and compare
        if (gap >= 10'sd0) begin
          wa_nxt = {74'd0, ma}; wb_nxt = {74'd0, mb}; cnt_nxt = 8'(gap);
          e_nxt = 11'(eb); sx_nxt = na; sy_nxt = nb; xa_nxt = 1'b1;
        end else begin
          wa_nxt = {74'd0, mb}; wb_nxt = {74'd0, ma}; cnt_nxt = 8'(-gap);
          e_nxt = 11'(ea); sx_nxt = nb; sy_nxt = na; xa_nxt = 1'b0;
        end
        case (cmd_r)
          dfa_pkg::CMD_ADD: begin
            if (a_r[63] || b_r[63]) st_nxt = dfa_pkg::ST_RANGE;
            else if (a_r == 64'd0) res_nxt = b_r;
            else if (b_r == 64'd0) res_nxt = a_r;
            else if (gap > dfa_pkg::GAP_LIMIT) res_nxt = a_r;
            else if (gap < -dfa_pkg::GAP_LIMIT) res_nxt = b_r;
            else state_nxt = S_SCALE;
          end
          dfa_pkg::CMD_MUL: begin
            if (a_r[63] || b_r[63]) st_nxt = dfa_pkg::ST_RANGE;
            else begin
              wa_nxt = 128'd0; e_nxt = 11'(ea) + 11'(eb); neg_nxt = na ^ nb;
              step_nxt = 2'd0; state_nxt = S_MUL;
            end
          end
          dfa_pkg::CMD_CMP: begin
            if (a_r[63] || b_r[63]) st_nxt = dfa_pkg::ST_RANGE;
            else if (mode_r == 3'd0 || mode_r == 3'd7) st_nxt = dfa_pkg::ST_BAD_ARG;
            else if (ma == 54'd0 && mb == 54'd0) res_nxt = {63'd0, mode_r[1]};
            else if (na != nb) res_nxt = {63'd0, na ? mode_r[0] : mode_r[2]};
            else if (gap > dfa_pkg::GAP_LIMIT)
              res_nxt = {63'd0, rel_bit(ma != 54'd0, ma == 54'd0, na, mode_r)};
            else if (gap < -dfa_pkg::GAP_LIMIT)
              res_nxt = {63'd0, rel_bit(mb == 54'd0, mb != 54'd0, na, mode_r)};
            else state_nxt = S_SCALE;
          end
          dfa_pkg::CMD_NORM: begin
            wa_nxt = {64'd0, nmag}; e_nxt = 11'($signed(exp_r)); neg_nxt = a_r[63];
            state_nxt = S_PK_HI;
          end
          dfa_pkg::CMD_TOINT: begin
            wa_nxt = {74'd0, ma}; wb_nxt = dfa_pkg::INT_LIMIT;
            idx_nxt = 3'd3; rem_nxt = 4'd0;
            if (dp_r > 5'd15) st_nxt = dfa_pkg::ST_BAD_ARG;
            else if (a_r[63]) st_nxt = dfa_pkg::ST_RANGE;
            else if (na && !take_r) st_nxt = dfa_pkg::ST_NEGATIVE;
            else if (ma == 54'd0 || kk == 10'sd0) res_nxt = {10'd0, ma};
            else if (kk < 10'sd0) begin
              cnt_nxt = (negk > 10'sd21) ? dfa_pkg::DIV_CAP : 8'(negk);
              state_nxt = S_DIV;
            end else begin
              cnt_nxt = 8'(kk); state_nxt = S_TI_MUL;
            end
          end
          dfa_pkg::CMD_NEG: begin
            if (a_r[63]) st_nxt = dfa_pkg::ST_RANGE;
            else if (a_r != 64'd0) res_nxt = a_r ^ (64'd1 << 62);
          end
          default: st_nxt = dfa_pkg::ST_BAD_ARG;
        endcase
      end
      // scale the operand with the larger exponent
      S_SCALE: begin
        if (cnt_r == 8'd0) state_nxt = S_CMP;
        else begin
          wa_nxt = u_res; cnt_nxt = cnt_r - 8'd1;
        end
      end
      S_CMP: begin
        gt_nxt = sts.gt;
        if (cmd_r == dfa_pkg::CMD_CMP) begin
          res_nxt = {63'd0, rel_bit(a_gt, a_lt, na, mode_r)};
          state_nxt = S_OUT;
        end else state_nxt = S_ARITH;
      end
      S_ARITH: begin
        wa_nxt  = u_res;
        neg_nxt = (sx_r == sy_r) ? sx_r : (gt_r ? sx_r : sy_r);
        state_nxt = S_PK_HI;
      end
      // 27x27 partial products
      S_MUL: begin
        wa_nxt = u_res; step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) state_nxt = S_PK_HI;
      end
      S_PK_HI: begin
        if (wa_r == 128'd0) begin
          res_nxt = 64'd0; state_nxt = S_OUT;
        end else if (sts.gt) begin
          idx_nxt = 3'd7; rem_nxt = 4'd0; state_nxt = S_DIV;
        end else state_nxt = S_PK_LO;
      end
      S_PK_LO: begin
        if (u_lt) begin
          wa_nxt = u_res; e_nxt = e_r - 11'sd1;
        end else begin
          state_nxt = S_OUT;
          if (e_r < dfa_pkg::EXP_LOW || e_r > dfa_pkg::EXP_HIGH) begin
            st_nxt = dfa_pkg::ST_RANGE; res_nxt = 64'd0;
          end else begin
            res_nxt = {1'b0, !neg_r, 8'(e_r + dfa_pkg::EXP_BIAS), wa_r[53:0]};
          end
        end
      end
      // one limb of a divide by ten per cycle, top limb first
      S_DIV: begin
        wa_nxt = u_res; rem_nxt = sts.rem; idx_nxt = idx_r - 3'd1;
        if (idx_r == 3'd0) begin
          if (cmd_r == dfa_pkg::CMD_TOINT) begin
            idx_nxt = 3'd3; rem_nxt = 4'd0; cnt_nxt = cnt_r - 8'd1;
            if (cnt_r == 8'd1) begin
              res_nxt = u_res[63:0]; state_nxt = S_OUT;
            end
          end else begin
            e_nxt = e_r + 11'sd1; state_nxt = S_PK_HI;
          end
        end
      end
      S_TI_MUL: begin
        if (cnt_r == 8'd0) begin
          res_nxt = wa_r[63:0]; state_nxt = S_OUT;
        end else if (sts.gt) begin
          st_nxt = dfa_pkg::ST_OVERFLOW; res_nxt = 64'd0; state_nxt = S_OUT;
        end else begin
          wa_nxt = u_res; cnt_nxt = cnt_r - 8'd1;
        end
      end
      S_OUT: begin
        if (out_chan.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (state_r == S_IDLE && in_chan.valid) begin
      cmd_r  <= in_chan.cmd;
      a_r    <= in_chan.operand_a;
      b_r    <= in_chan.operand_b;
      exp_r  <= in_chan.exponent_in;
      mode_r <= in_chan.compare_mode;
      dp_r   <= in_chan.frac_digits;
      take_r <= in_chan.take_magnitude;
    end
    wa_r <= wa_nxt;   wb_r <= wb_nxt;   e_r <= e_nxt;
    neg_r <= neg_nxt; sx_r <= sx_nxt;   sy_r <= sy_nxt; xa_r <= xa_nxt; gt_r <= gt_nxt;
    cnt_r <= cnt_nxt; idx_r <= idx_nxt; rem_r <= rem_nxt; step_r <= step_nxt;
    res_r <= res_nxt; st_r <= st_nxt;
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = (state_r == S_OUT);
  assign out_chan.result_value = res_r;
  assign out_chan.status       = st_r;

endmodule

>>> tb/dfa_tb_if.sv
// no separate interface file needed beyond the rtl's dfa_if; this file holds testbench helpers
// depends on dfa_pkg for the command and status codes
package dfa_tb_pkg;

  typedef struct {
    logic [2:0]  cmd;
    logic [63:0] a;
    logic [63:0] b;
    logic [7:0]  exp_in;
    logic [2:0]  mode;
    logic [4:0]  dp;
    logic        take_mag;
  } alu_req_t;

  typedef struct {
    logic [63:0] value;
    logic [2:0]  status;
  } alu_res_t;

  localparam logic [127:0] M_LO = 128'd1000000000000000;
  localparam logic [127:0] M_HI = 128'd9999999999999999;
  localparam logic [63:0]  MANT_FIELD = (64'd1 << 54) - 64'd1;
  localparam int           GAP = 20;

  function automatic logic [127:0] pow10_scale(logic [63:0] m, int n);
    logic [127:0] r;
    r = {64'd0, m};
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  // word decode: returns 1 when bit 63 is set
  function automatic bit unpack_word(logic [63:0] w, output logic [63:0] m, output int e,
                                     output bit neg);
    m = 0; e = 0; neg = 0;
    if (w[63]) return 1;
    if (w == 0) return 0;
    m = w & MANT_FIELD;
    e = int'(w[61:54]) - 97;
    neg = !w[62];
    return 0;
  endfunction

  // normalize to 16 digits and encode, returns status
  function automatic logic [2:0] encode_float(logic [127:0] m, int e, bit neg,
                                              output logic [63:0] w);
    w = 0;
    if (m == 0) return dfa_pkg::ST_OK;
    while (m > M_HI) begin m = m / 10; e++; end
    while (m < M_LO) begin m = m * 10; e--; end
    if (e < -96 || e > 80) return dfa_pkg::ST_RANGE;
    w = m[63:0] | (64'(e + 97) << 54);
    if (!neg) w[62] = 1'b1;
    return dfa_pkg::ST_OK;
  endfunction

  function automatic int mag_order(logic [63:0] ma, int ea, logic [63:0] mb, int eb);
    logic [127:0] x, y;
    if (ea - eb > GAP) return ma == 0 ? (mb == 0 ? 0 : -1) : 1;
    if (eb - ea > GAP) return mb == 0 ? (ma == 0 ? 0 : 1) : -1;
    if (ea >= eb) begin x = pow10_scale(ma, ea - eb); y = {64'd0, mb}; end
    else begin x = {64'd0, ma}; y = pow10_scale(mb, eb - ea); end
    return x < y ? -1 : (x > y ? 1 : 0);
  endfunction

  // expected result of one request
  function automatic alu_res_t predict_alu(alu_req_t q);
    alu_res_t r;
    logic [63:0] ma, mb, res, ri, mag;
    int ea, eb, e, k, rel, c;
    bit na, nb, neg;
    logic [2:0] st;
    logic [127:0] x, y, s;
    res = 0; st = dfa_pkg::ST_OK; ma = 0; mb = 0; ea = 0; eb = 0; na = 0; nb = 0;
    if (q.cmd <= dfa_pkg::CMD_CMP) begin
      if (unpack_word(q.a, ma, ea, na) || unpack_word(q.b, mb, eb, nb))
        st = dfa_pkg::ST_RANGE;
    end else if (q.cmd == dfa_pkg::CMD_TOINT || q.cmd == dfa_pkg::CMD_NEG) begin
      if (q.cmd == dfa_pkg::CMD_TOINT && q.dp > 15) st = dfa_pkg::ST_BAD_ARG;
      else if (unpack_word(q.a, ma, ea, na)) st = dfa_pkg::ST_RANGE;
    end else if (q.cmd > dfa_pkg::CMD_NEG) st = dfa_pkg::ST_BAD_ARG;
    if (st == dfa_pkg::ST_OK) begin
      case (q.cmd)
        dfa_pkg::CMD_ADD: begin
          if (q.a == 0) res = q.b;
          else if (q.b == 0) res = q.a;
          else if (ea - eb > GAP) res = q.a;
          else if (eb - ea > GAP) res = q.b;
          else begin
            if (ea >= eb) begin x = pow10_scale(ma, ea - eb); y = {64'd0, mb}; e = eb; end
            else begin x = {64'd0, ma}; y = pow10_scale(mb, eb - ea); e = ea; end
            if (na == nb) begin s = x + y; neg = na; end
            else if (x > y) begin s = x - y; neg = na; end
            else begin s = y - x; neg = nb; end
            st = encode_float(s, e, neg, res);
          end
        end
        dfa_pkg::CMD_MUL:
          st = encode_float({64'd0, ma} * {64'd0, mb}, ea + eb, na != nb, res);
        dfa_pkg::CMD_CMP: begin
          if (q.mode == 0 || q.mode == 7) st = dfa_pkg::ST_BAD_ARG;
          else begin
            c = mag_order(ma, ea, mb, eb);
            if (ma == 0 && mb == 0) rel = 0;
            else if (na != nb) rel = na ? -1 : 1;
            else rel = na ? -c : c;
            res = 64'(q.mode[rel + 1]);
          end
        end
        dfa_pkg::CMD_NORM: begin
          neg = q.a[63];
          mag = neg ? -q.a : q.a;
          st = encode_float({64'd0, mag}, int'($signed(q.exp_in)), neg, res);
        end
        dfa_pkg::CMD_TOINT: begin
          if (na && !q.take_mag) st = dfa_pkg::ST_NEGATIVE;
          else begin
            k = ea + int'(q.dp);
            ri = ma;
            if (k < 0) begin
              for (int i = 0; i < -k && i <= GAP; i++) ri = ri / 10;
            end else begin
              for (int i = 0; i < k; i++) begin
                if (ri > 64'd922337203685477580) begin st = dfa_pkg::ST_OVERFLOW; break; end
                ri = ri * 10;
              end
            end
            res = ri;
          end
        end
        default: res = (q.a == 0) ? 64'd0 : (q.a ^ (64'd1 << 62));
      endcase
    end
    if (st != dfa_pkg::ST_OK) res = 0;
    r.value = res;
    r.status = st;
    return r;
  endfunction
endpackage

>>> tb/decimal_float_alu_top_tb.sv
// testbench for decimal_float_alu_top: directed and random requests, checked by a predictor
// depends on dfa_pkg, dfa_if and dfa_tb_pkg
module decimal_float_alu_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   err_count = 0;
  bit   stim_done = 1'b0;
  int   stall_left = 0;
  int   gap_left = 0;
  bit   in_taken = 1'b0;

  dfa_tb_pkg::alu_req_t req_pending[$];
  dfa_tb_pkg::alu_res_t res_expected[$];

  dfa_req_if in_chan();
  dfa_rsp_if out_chan();

  decimal_float_alu_top u_top (.clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan));

  always #6 clk = ~clk;

  // mostly no gap or a short one, sometimes long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] m;
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) m = 64'($urandom_range(0, 8999)) * 64'd1000000000000 + 64'd1000000000000000
                    + 64'($urandom_range(0, 999999999));
    else if (p < 85) m = 64'($urandom_range(1, 1000000));
    else m = {$urandom, $urandom} & dfa_tb_pkg::MANT_FIELD;
    return m | (64'($urandom_range(0, 255)) << 54) | (64'($urandom_range(0, 1)) << 62);
  endfunction

  function automatic logic [63:0] near_word(logic [63:0] w);
    int e;
    e = int'(w[61:54]) + $urandom_range(0, 6) - 3;
    if (e < 0) e = 0;
    if (e > 255) e = 255;
    w[61:54] = e[7:0];
    return w;
  endfunction

  task automatic push_req(logic [2:0] cmd, logic [63:0] a, logic [63:0] b, logic [7:0] ex,
                          logic [2:0] mode, logic [4:0] dp, logic tm);
    dfa_tb_pkg::alu_req_t q;
    q.cmd = cmd; q.a = a; q.b = b; q.exp_in = ex; q.mode = mode; q.dp = dp; q.take_mag = tm;
    req_pending.push_back(q);
  endtask

  // stimulus
  initial begin
    logic [63:0] one, two, wa, wb, wn;
    int p;
    one = 64'd1000000000000000 | (64'(97 - 15) << 54) | (64'd1 << 62);
    two = 64'd2000000000000000 | (64'(97 - 15) << 54) | (64'd1 << 62);
    push_req(dfa_pkg::CMD_ADD, 0, one, 0, 1, 0, 0);
    push_req(dfa_pkg::CMD_ADD, one, one ^ (64'd1 << 62), 0, 1, 0, 0);
    push_req(dfa_pkg::CMD_ADD, one, one | (64'd30 << 54), 0, 1, 0, 0);
    push_req(dfa_pkg::CMD_ADD, {1'b1, 63'd5}, one, 0, 1, 0, 0);
    push_req(dfa_pkg::CMD_MUL, 64'h3FFF_FFFF_FFFF_FFFF, 64'h3FFF_FFFF_FFFF_FFFF, 0, 1, 0, 0);
    push_req(dfa_pkg::CMD_MUL, 64'h4000_0000_0000_0001, 64'h4000_0000_0000_0001, 0, 1, 0, 0);
    push_req(dfa_pkg::CMD_CMP, one, two, 0, 3'b001, 0, 0);
    push_req(dfa_pkg::CMD_CMP, 0, 64'd1 << 62, 0, 3'b010, 0, 0);
    push_req(dfa_pkg::CMD_CMP, one, two, 0, 3'b000, 0, 0);
    push_req(dfa_pkg::CMD_CMP, one, two, 0, 3'b111, 0, 0);
    push_req(dfa_pkg::CMD_NORM, 64'h8000_0000_0000_0000, 0, 8'h80, 1, 0, 0);
    push_req(dfa_pkg::CMD_NORM, 64'h7FFF_FFFF_FFFF_FFFF, 0, 8'h7F, 1, 0, 0);
    push_req(dfa_pkg::CMD_NORM, 64'd0, 0, 8'd5, 1, 0, 0);
    push_req(dfa_pkg::CMD_NORM, -64'sd42, 0, 8'd0, 1, 0, 0);
    push_req(dfa_pkg::CMD_TOINT, two, 0, 0, 1, 5'd0, 0);
    push_req(dfa_pkg::CMD_TOINT, two, 0, 0, 1, 5'd16, 0);
    push_req(dfa_pkg::CMD_TOINT, two, 0, 0, 1, 5'd31, 1);
    push_req(dfa_pkg::CMD_TOINT, two ^ (64'd1 << 62), 0, 0, 1, 5'd3, 0);
    push_req(dfa_pkg::CMD_TOINT, two ^ (64'd1 << 62), 0, 0, 1, 5'd3, 1);
    push_req(dfa_pkg::CMD_TOINT, one | (64'd100 << 54), 0, 0, 1, 5'd15, 0);
    push_req(dfa_pkg::CMD_NEG, 0, 0, 0, 1, 0, 0);
    push_req(dfa_pkg::CMD_NEG, one, 0, 0, 1, 0, 0);
    push_req(3'd6, one, one, 0, 1, 0, 0);
    push_req(3'd7, one, one, 0, 1, 0, 0);
    for (int i = 0; i < 1200; i++) begin
      wa = rand_word();
      p = $urandom_range(0, 99);
      wb = (p < 50) ? near_word(rand_word()) : (p < 60 ? wa : rand_word());
      wn = near_word(wa);
      if (p < 50) wb[61:54] = wn[61:54];
      if ($urandom_range(0, 19) == 0) wa = 0;
      if ($urandom_range(0, 19) == 0) wb = 0;
      if ($urandom_range(0, 29) == 0) wa[63] = 1'b1;
      if ($urandom_range(0, 29) == 0) wb[63] = 1'b1;
      p = $urandom_range(0, 99);
      push_req(p < 95 ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7)),
               $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : wa, wb,
               8'($urandom), 3'($urandom), $urandom_range(0, 3) == 0 ? 5'($urandom)
               : 5'($urandom_range(0, 15)), 1'($urandom));
    end
    stim_done = 1'b1;
  end

  // reset
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  // driver start values; the request driver below changes on the falling edge
  initial begin
    in_chan.valid = 1'b0;
    in_chan.cmd = '0; in_chan.operand_a = '0; in_chan.operand_b = '0;
    in_chan.exponent_in = '0; in_chan.compare_mode = '0; in_chan.frac_digits = '0;
    in_chan.take_magnitude = 1'b0;
    out_chan.ready = 1'b0;
  end

  // request acceptance seen at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_chan.valid && in_chan.ready;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        res_expected.push_back(dfa_tb_pkg::predict_alu(req_pending.pop_front()));
        gap_left = pick_gap();
      end
      if (!in_chan.valid || in_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (req_pending.size() > 0) begin
          in_chan.valid <= 1'b1;
          in_chan.cmd <= req_pending[0].cmd;
          in_chan.operand_a <= req_pending[0].a;
          in_chan.operand_b <= req_pending[0].b;
          in_chan.exponent_in <= req_pending[0].exp_in;
          in_chan.compare_mode <= req_pending[0].mode;
          in_chan.frac_digits <= req_pending[0].dp;
          in_chan.take_magnitude <= req_pending[0].take_mag;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
      // result side stalls
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_chan.ready <= (stall_left == 0);
      end
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    dfa_tb_pkg::alu_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (res_expected.size() == 0) begin
        $error("result with no request outstanding: value %h", out_chan.result_value);
        err_count++;
      end else begin
        want = res_expected.pop_front();
        if (out_chan.result_value !== want.value) begin
          $error("result_value expected %h got %h", want.value, out_chan.result_value);
          err_count++;
        end
        if (out_chan.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_chan.status);
          err_count++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (req_pending.size() == 0 && !in_chan.valid);
    wait (res_expected.size() == 0);
    repeat (300) @(posedge clk);
    if (err_count == 0 && res_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // timeout
  initial begin
    #(12ns * 4000000);
    $display("FAILURE");
    $finish;
  end
endmodule
